[rtl/core/ctlex_pkg.sv]
// Shared types and constants for the configuration token lexer.
// Used by ctlex_step, ctlex_out_fifo and config_token_lexer_unit; no dependencies.
package ctlex_pkg;

    // Default width of the line counter.
    localparam int LINE_BITS_DEF = 32;

    // Width of the line number carried by every result.
    localparam int LINE_OUT_W = 32;

    // Result kinds.
    localparam logic [1:0] K_BYTE = 2'd0;
    localparam logic [1:0] K_TEND = 2'd1;
    localparam logic [1:0] K_EOI  = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    // Error codes.
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_EOL_QUOTE = 3'd1;
    localparam logic [2:0] E_BAD_QUOTE = 3'd2;
    localparam logic [2:0] E_EOL_ESC   = 3'd3;
    localparam logic [2:0] E_BAD_ESC   = 3'd4;

    // Character codes.
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;

    // Output FIFO depth and the sizes that follow from it.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One result item.
    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            out_byte;
        logic [2:0]            error_code;
        logic [LINE_OUT_W-1:0] line_number;
        logic                  last;
    } t_result;

    // What the step logic hands to the output FIFO in one cycle.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step_out;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

[rtl/core/ctlex_step.sv]
// Lexer mode machine: holds the mode, quote and line state and turns one
// registered input byte into zero, one or two results. Depends on ctlex_pkg.
module ctlex_step
    import ctlex_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    output t_step_out  o_step
);

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_TOKEN   = 3'd2,
        MODE_QUOTE   = 3'd3,
        MODE_ESCAPE  = 3'd4,
        MODE_HALTED  = 3'd5,
        MODE_DONE    = 3'd6
    } t_mode;

    t_mode                r_mode, n_mode;
    logic                 r_quote, n_quote;
    logic [LINE_BITS-1:0] r_line, n_line;

    logic                        bump;
    logic                        do_tok;
    logic                        do_err;
    logic [2:0]                  err_code;
    logic [7:0]                  esc_byte;
    logic [LINE_BITS+LINE_OUT_W-1:0] line_ext;
    logic [LINE_OUT_W-1:0]       line_now;
    logic [7:0]                  close_q;

    assign line_ext = {{LINE_OUT_W{1'b0}}, r_line};
    assign line_now = line_ext[LINE_OUT_W-1:0];
    assign close_q  = r_quote ? CH_SQ : CH_DQ;

    always_comb begin
        n_mode   = r_mode;
        n_quote  = r_quote;
        bump     = 1'b0;
        do_tok   = 1'b0;
        do_err   = 1'b0;
        err_code = E_NONE;
        esc_byte = i_byte;
        o_step.count = 2'd0;
        o_step.res0  = '{kind: K_BYTE, out_byte: 8'd0, error_code: E_NONE,
                         line_number: line_now, last: 1'b1};
        o_step.res1  = '{kind: K_EOI, out_byte: 8'd0, error_code: E_NONE,
                         line_number: line_now, last: 1'b1};

        case (r_mode)
            MODE_BETWEEN: begin
                if (i_eoi) begin
                    n_mode = MODE_DONE;
                    o_step.res0.kind = K_EOI;
                    o_step.count = 2'd1;
                end else if (i_byte == CH_HASH) begin
                    n_mode = MODE_COMMENT;
                end else if (is_sep(i_byte)) begin
                    bump = (i_byte == CH_LF);
                end else begin
                    do_tok = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (i_eoi) begin
                    n_mode = MODE_DONE;
                    o_step.res0.kind = K_EOI;
                    o_step.count = 2'd1;
                end else if (i_byte == CH_LF) begin
                    bump   = 1'b1;
                    n_mode = MODE_BETWEEN;
                end
            end
            MODE_TOKEN: begin
                if (i_eoi) begin
                    n_mode = MODE_DONE;
                    o_step.res0.kind = K_TEND;
                    o_step.res0.last = 1'b0;
                    o_step.count = 2'd2;
                end else if ((i_byte == CH_HASH) || is_sep(i_byte)) begin
                    o_step.res0.kind = K_TEND;
                    o_step.count = 2'd1;
                    n_mode = (i_byte == CH_HASH) ? MODE_COMMENT : MODE_BETWEEN;
                    bump   = (i_byte == CH_LF);
                end else begin
                    do_tok = 1'b1;
                end
            end
            MODE_QUOTE: begin
                if (i_eoi || (i_byte == CH_LF)) begin
                    do_err   = 1'b1;
                    err_code = E_EOL_QUOTE;
                end else if (i_byte == close_q) begin
                    n_mode = MODE_TOKEN;
                end else if ((i_byte == CH_TAB) || (i_byte == CH_CR)) begin
                    do_err   = 1'b1;
                    err_code = E_BAD_QUOTE;
                end else begin
                    o_step.res0.out_byte = i_byte;
                    o_step.count = 2'd1;
                end
            end
            MODE_ESCAPE: begin
                if (i_eoi || (i_byte == CH_LF)) begin
                    do_err   = 1'b1;
                    err_code = E_EOL_ESC;
                end else begin
                    case (i_byte)
                        CH_T:     esc_byte = CH_TAB;
                        CH_N:     esc_byte = CH_LF;
                        CH_R:     esc_byte = CH_CR;
                        CH_SPACE,
                        CH_DQ,
                        CH_HASH,
                        CH_SQ,
                        CH_BSL:   esc_byte = i_byte;
                        default: begin
                            do_err   = 1'b1;
                            err_code = E_BAD_ESC;
                        end
                    endcase
                    if (!do_err) begin
                        n_mode = MODE_TOKEN;
                        o_step.res0.out_byte = esc_byte;
                        o_step.count = 2'd1;
                    end
                end
            end
            default: begin
                // Halted or done: input is swallowed without a result.
            end
        endcase

        // A byte that belongs to a token.
        if (do_tok) begin
            if ((i_byte == CH_DQ) || (i_byte == CH_SQ)) begin
                n_quote = (i_byte == CH_SQ);
                n_mode  = MODE_QUOTE;
            end else if (i_byte == CH_BSL) begin
                n_mode = MODE_ESCAPE;
            end else begin
                n_mode = MODE_TOKEN;
                o_step.res0.out_byte = i_byte;
                o_step.count = 2'd1;
            end
        end

        if (do_err) begin
            n_mode = MODE_HALTED;
            o_step.res0.kind       = K_ERR;
            o_step.res0.error_code = err_code;
            o_step.count = 2'd1;
        end

        n_line = r_line;
        if (bump && (r_line != {LINE_BITS{1'b1}})) begin
            n_line = r_line + {{(LINE_BITS-1){1'b0}}, 1'b1};
        end

        // Nothing happens without a valid input.
        if (!i_valid) begin
            n_mode  = r_mode;
            n_quote = r_quote;
            n_line  = r_line;
            o_step.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BETWEEN;
            r_quote <= 1'b0;
            r_line  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
        end else begin
            r_mode  <= n_mode;
            r_quote <= n_quote;
            r_line  <= n_line;
        end
    end

endmodule

[rtl/core/ctlex_out_fifo.sv]
// Small result FIFO: takes up to two results per cycle, gives one per cycle.
// Depends on ctlex_pkg.
module ctlex_out_fifo
    import ctlex_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_step_out          i_push,
    input  logic               i_pop,
    output logic               o_valid,
    output t_result            o_head,
    output logic [FIFO_CW-1:0] o_count
);

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, n_wptr;
    logic [FIFO_AW-1:0] r_rptr, n_rptr;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic [FIFO_AW-1:0] wptr_p1;
    logic               pop_ok;

    assign wptr_p1 = r_wptr + {{(FIFO_AW-1){1'b0}}, 1'b1};
    assign pop_ok  = i_pop && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr + FIFO_AW'(i_push.count);
        n_rptr  = r_rptr + {{(FIFO_AW-1){1'b0}}, pop_ok};
        n_count = r_count + FIFO_CW'(i_push.count) - {{(FIFO_CW-1){1'b0}}, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wptr_p1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

[rtl/core/config_token_lexer_unit.sv]
// Top level of the configuration token lexer: input register, mode machine
// and result FIFO. Depends on ctlex_pkg, ctlex_step and ctlex_out_fifo.
//
// Usage:
//   The slave channel carries one raw text byte per transfer in s_axis_tdata;
//   s_axis_tlast high marks the end of the text, and the byte is then ignored.
//   The master channel carries one result per transfer: m_axis_tuser is the
//   result kind (token byte, token end, end of input, error), m_axis_tlast is
//   high on the final result caused by one input byte.
// A result passes the input register and the result FIFO before it can be taken.
// Throughput: one input byte per cycle unless stalled. Each byte yields at most
//   one result, except end of input inside a token, which yields a token end and
//   an end of input in the same cycle; then the block is done and gives no more.
// The input register is consumed only while the result FIFO has room for two
//   results, so a stalled receiver fills the FIFO and then holds s_axis_tready
//   low; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the FIFO and the input register,
//   returns the lexer to the between-tokens mode and sets the line to one.
//   An error or end of input makes the block swallow all later input until
//   the next reset.
module config_token_lexer_unit
    import ctlex_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
    input  logic        s_axis_tlast,  // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [7:0] out_byte, [10:8] error_code,
                                       // [42:11] line_number, [47:43] zero
    output logic [1:0]  m_axis_tuser,  // [1:0] kind
    output logic        m_axis_tlast   // last
);

    // Input register between the slave channel and the mode machine.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;

    logic               proc;
    logic               in_xfer;
    t_step_out          step;
    t_result            head;
    logic [FIFO_CW-1:0] fifo_count;

    // The registered byte moves on only while the FIFO can take two results.
    assign proc          = r_in_valid && (fifo_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign s_axis_tready = !r_in_valid || proc;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= s_axis_tdata;
            r_in_eoi  <= s_axis_tlast;
        end
    end

    ctlex_step #(
        .LINE_BITS (LINE_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (proc),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_step  (step)
    );

    ctlex_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_head  (head),
        .o_count (fifo_count)
    );

    assign m_axis_tdata = {5'd0, head.line_number, head.error_code, head.out_byte};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    // The FIFO never holds more results than it has entries.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result FIFO overflow");

    // Two results from one byte only happen at end of input.
    a_pair_eoi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step.count == 2'd2) |-> (r_in_eoi && proc))
        else $error("two results without end of input");

    // An error code is present exactly on error results.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == K_ERR) == (m_axis_tdata[10:8] != E_NONE)))
        else $error("error code does not match result kind");

    // Only token bytes carry a nonzero byte.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != K_BYTE)) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("nonzero byte on a non-byte result");

endmodule

[tb/config_token_lexer_unit_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the configuration token lexer: tracks the lexer state from
// the accepted input transfers and checks every result transfer in order.
// Depends on ctlex_pkg for the result layout, kinds, error and character codes.
module config_token_lexer_unit_checker
    import ctlex_pkg::*;
#(
    parameter int LINE_BITS = LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_eoi,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [47:0] i_res_data,
    input  logic [1:0]  i_res_kind,
    input  logic        i_res_last,
    output int unsigned o_pending,
    output int unsigned o_fail_count
);

    localparam int LINE_LSB    = 11;
    localparam int PAD_LSB     = LINE_LSB + LINE_OUT_W;
    localparam int MAX_PRINTED = 40;

    typedef enum logic [2:0] {
        LX_BETWEEN,
        LX_COMMENT,
        LX_TOKEN,
        LX_QUOTE,
        LX_ESCAPE,
        LX_HALTED,
        LX_DONE
    } t_lex_mode;

    t_lex_mode            lex_mode        = LX_BETWEEN;
    logic                 in_single_quote = 1'b0;
    logic [LINE_BITS-1:0] line_count      = LINE_BITS'(1);
    logic [LINE_BITS-1:0] line_at_input   = LINE_BITS'(1);
    t_result              expected_results[$];
    int unsigned          mismatches      = 0;
    int unsigned          results_seen    = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    function automatic logic is_separator(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    // Every result carries the line as it stood before the input that caused it.
    function automatic void queue_result(input logic [1:0] kind, input logic [7:0] b,
                                         input logic [2:0] code, input logic ends_input);
        t_result r;
        r.kind        = kind;
        r.out_byte    = b;
        r.error_code  = code;
        r.line_number = LINE_OUT_W'(line_at_input);
        r.last        = ends_input;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void count_newline();
        if (line_count != {LINE_BITS{1'b1}}) begin
            line_count = line_count + 1'b1;
        end
    endfunction

    function automatic void raise_error(input logic [2:0] code);
        lex_mode = LX_HALTED;
        queue_result(K_ERR, 8'h00, code, 1'b1);
    endfunction

    // A byte that belongs to a token: opens a quote, starts an escape or is emitted.
    function automatic void take_token_char(input logic [7:0] c);
        if (c == CH_DQ || c == CH_SQ) begin
            in_single_quote = (c == CH_SQ);
            lex_mode = LX_QUOTE;
        end else if (c == CH_BSL) begin
            lex_mode = LX_ESCAPE;
        end else begin
            lex_mode = LX_TOKEN;
            queue_result(K_BYTE, c, E_NONE, 1'b1);
        end
    endfunction

    function automatic void lex_input(input logic [7:0] c, input logic eoi);
        logic [7:0] closing;
        logic [7:0] escaped;
        logic       escape_ok;
        line_at_input = line_count;
        case (lex_mode)
            LX_BETWEEN: begin
                if (eoi) begin
                    lex_mode = LX_DONE;
                    queue_result(K_EOI, 8'h00, E_NONE, 1'b1);
                end else if (c == CH_HASH) begin
                    lex_mode = LX_COMMENT;
                end else if (is_separator(c)) begin
                    if (c == CH_LF) count_newline();
                end else begin
                    take_token_char(c);
                end
            end
            LX_COMMENT: begin
                if (eoi) begin
                    lex_mode = LX_DONE;
                    queue_result(K_EOI, 8'h00, E_NONE, 1'b1);
                end else if (c == CH_LF) begin
                    count_newline();
                    lex_mode = LX_BETWEEN;
                end
            end
            LX_TOKEN: begin
                if (eoi) begin
                    lex_mode = LX_DONE;
                    queue_result(K_TEND, 8'h00, E_NONE, 1'b0);
                    queue_result(K_EOI, 8'h00, E_NONE, 1'b1);
                end else if (c == CH_HASH || is_separator(c)) begin
                    queue_result(K_TEND, 8'h00, E_NONE, 1'b1);
                    lex_mode = (c == CH_HASH) ? LX_COMMENT : LX_BETWEEN;
                    if (c == CH_LF) count_newline();
                end else begin
                    take_token_char(c);
                end
            end
            LX_QUOTE: begin
                closing = in_single_quote ? CH_SQ : CH_DQ;
                if (eoi || c == CH_LF) begin
                    raise_error(E_EOL_QUOTE);
                end else if (c == closing) begin
                    lex_mode = LX_TOKEN;
                end else if (c == CH_TAB || c == CH_CR) begin
                    raise_error(E_BAD_QUOTE);
                end else begin
                    queue_result(K_BYTE, c, E_NONE, 1'b1);
                end
            end
            LX_ESCAPE: begin
                if (eoi || c == CH_LF) begin
                    raise_error(E_EOL_ESC);
                end else begin
                    escape_ok = 1'b1;
                    escaped   = c;
                    case (c)
                        CH_T: escaped = CH_TAB;
                        CH_N: escaped = CH_LF;
                        CH_R: escaped = CH_CR;
                        CH_SPACE, CH_DQ, CH_HASH, CH_SQ, CH_BSL: escaped = c;
                        default: escape_ok = 1'b0;
                    endcase
                    if (escape_ok) begin
                        lex_mode = LX_TOKEN;
                        queue_result(K_BYTE, escaped, E_NONE, 1'b1);
                    end else begin
                        raise_error(E_BAD_ESC);
                    end
                end
            end
            default: begin
                // Halted or done: everything is swallowed until reset.
            end
        endcase
    endfunction

    // Printing stops after a while so a badly broken block cannot flood the log.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("ERROR: result %0d, %s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        end
    endtask

    task automatic check_result();
        t_result want;
        results_seen++;
        if (expected_results.size() == 0) begin
            report_mismatch("kind of a result with nothing expected", 64'(i_res_kind),
                            64'd0);
        end else begin
            want = expected_results.pop_front();
            if (i_res_kind !== want.kind)
                report_mismatch("kind", 64'(i_res_kind), 64'(want.kind));
            if (i_res_data[7:0] !== want.out_byte)
                report_mismatch("out_byte", 64'(i_res_data[7:0]), 64'(want.out_byte));
            if (i_res_data[10:8] !== want.error_code)
                report_mismatch("error_code", 64'(i_res_data[10:8]),
                                64'(want.error_code));
            if (i_res_data[PAD_LSB-1:LINE_LSB] !== want.line_number)
                report_mismatch("line_number", 64'(i_res_data[PAD_LSB-1:LINE_LSB]),
                                64'(want.line_number));
            if (i_res_data[47:PAD_LSB] !== '0)
                report_mismatch("tdata padding", 64'(i_res_data[47:PAD_LSB]), 64'd0);
            if (i_res_last !== want.last)
                report_mismatch("last", 64'(i_res_last), 64'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lex_mode        = LX_BETWEEN;
            in_single_quote = 1'b0;
            line_count      = LINE_BITS'(1);
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_result();
            if (i_in_valid && i_in_ready) lex_input(i_in_byte, i_in_eoi);
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

[tb/config_token_lexer_unit_test.sv]
`timescale 1ns / 1ps
// Testbench top for config_token_lexer_unit: clock, reset, text stimulus,
// receiver stalls, watchdog and verdict. Depends on ctlex_pkg, the lexer RTL
// and config_token_lexer_unit_checker, which predicts and compares results.
module config_token_lexer_unit_test;
    import ctlex_pkg::*;

    localparam int LINE_BITS      = LINE_BITS_DEF;
    localparam int RANDOM_ITEMS   = 450;
    localparam int WATCHDOG_LIMIT = 2000;
    // Results pass the input register and the result FIFO; wait well past the last one.
    localparam int TAIL_CYCLES    = 12;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0;    // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;            // [7:0] out_byte, [10:8] error_code,
                                          // [42:11] line_number, [47:43] zero
    logic [1:0]  m_axis_tuser;            // [1:0] kind
    logic        m_axis_tlast;            // last

    int unsigned pending_results;
    int unsigned fail_count;

    always #5 i_clk = ~i_clk;

    config_token_lexer_unit #(
        .LINE_BITS(LINE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    config_token_lexer_unit_checker #(
        .LINE_BITS(LINE_BITS)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_in_eoi     (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_kind   (m_axis_tuser),
        .i_res_last   (m_axis_tlast),
        .o_pending    (pending_results),
        .o_fail_count (fail_count)
    );

    // ------------------------------------------------------------------
    // Receiver: the ready pattern switches from phase to phase between
    // always ready, coin flips, sparse acceptance and long stalls, so the
    // result FIFO both runs dry and fills up, pushing back on the sender.
    // ------------------------------------------------------------------
    int unsigned rx_mode       = 0;
    int unsigned rx_phase_left = 0;

    always @(posedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       <= $urandom_range(0, 3);
            rx_phase_left <= $urandom_range(64, 256);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_phase_left[4:0] < 5'd4);
        endcase
    end

    // ------------------------------------------------------------------
    // Watchdog: a run in which no transfer happens on either side for too
    // long is stuck, whatever the reason.
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Bytes go out in bursts of random length; between bursts the
    // valid line drops for a random gap, and a third of the gaps are empty,
    // which gives long stretches of back-to-back transfers.
    // ------------------------------------------------------------------
    int unsigned burst_left     = 0;
    int unsigned items_accepted = 0;

    task automatic send_item(input logic [7:0] b, input logic eoi);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        do @(posedge i_clk); while (!s_axis_tready);
        items_accepted++;
    endtask

    // Holds the sender off until every predicted result has been taken.
    // Valid is dropped before the wait begins, so it is never lowered
    // and raised in the same step.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    // The eight letters that may follow a backslash.
    function automatic logic [7:0] escape_letter(input int unsigned idx);
        case (idx)
            0: return CH_T;
            1: return CH_N;
            2: return CH_R;
            3: return CH_SPACE;
            4: return CH_DQ;
            5: return CH_HASH;
            6: return CH_SQ;
            default: return CH_BSL;
        endcase
    endfunction

    function automatic logic is_escape_letter(input logic [7:0] c);
        for (int unsigned i = 0; i < 8; i++) begin
            if (c == escape_letter(i)) return 1'b1;
        end
        return 1'b0;
    endfunction

    // A byte that stays a plain token byte: no separator, comment start,
    // quote or backslash.
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
                   c == CH_HASH || c == CH_DQ || c == CH_SQ || c == CH_BSL);
        return c;
    endfunction

    // A well-formed token made of plain runs, quoted strings and escapes.
    // Quoted text may hold the other quote, '#', backslash and any high byte.
    task automatic send_token();
        int unsigned pieces;
        int unsigned count;
        logic [7:0]  quote;
        logic [7:0]  c;
        pieces = $urandom_range(1, 6);
        repeat (pieces) begin
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    count = $urandom_range(1, 4);
                    repeat (count) send_item(plain_byte(), 1'b0);
                end
                3, 4: begin
                    quote = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
                    send_item(quote, 1'b0);
                    count = $urandom_range(0, 6);
                    repeat (count) begin
                        do begin
                            c = 8'($urandom_range(0, 255));
                        end while (c == quote || c == CH_LF || c == CH_TAB || c == CH_CR);
                        send_item(c, 1'b0);
                    end
                    send_item(quote, 1'b0);
                end
                default: begin
                    send_item(CH_BSL, 1'b0);
                    send_item(escape_letter($urandom_range(0, 7)), 1'b0);
                end
            endcase
        end
    endtask

    // A comment with random content, closed by a newline.
    task automatic send_comment();
        int unsigned count;
        logic [7:0]  c;
        send_item(CH_HASH, 1'b0);
        count = $urandom_range(0, 10);
        repeat (count) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
            send_item(c, 1'b0);
        end
        send_item(CH_LF, 1'b0);
    endtask

    task automatic send_separators();
        int unsigned count;
        count = $urandom_range(1, 3);
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: send_item(CH_SPACE, 1'b0);
                1: send_item(CH_TAB, 1'b0);
                2: send_item(CH_CR, 1'b0);
                default: send_item(CH_LF, 1'b0);
            endcase
        end
    endtask

    // Short directed text: the byte extremes as a token ended by a comment,
    // every escape in one token ended by a newline, empty quotes that still
    // open a token, and the other quote character passing through quotes.
    task automatic send_directed();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_HASH, 1'b0);
        send_item(CH_LF, 1'b0);
        for (int unsigned i = 0; i < 8; i++) begin
            send_item(CH_BSL, 1'b0);
            send_item(escape_letter(i), 1'b0);
        end
        send_item(CH_LF, 1'b0);
        send_item(CH_SQ, 1'b0);
        send_item(CH_SQ, 1'b0);
        send_item(CH_DQ, 1'b0);
        send_item(CH_SQ, 1'b0);
        send_item(CH_DQ, 1'b0);
        send_item(CH_TAB, 1'b0);
    endtask

    // Since only one reset is allowed, the run can end in only one way: either
    // a clean end of input or one of the errors. Each seed picks one; the
    // bytes after it must all be swallowed without any result.
    task automatic send_ending();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: begin
                send_item(CH_SPACE, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                send_item(plain_byte(), 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            2: begin
                send_item(CH_HASH, 1'b0);
                send_item(plain_byte(), 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            3: begin
                send_item(CH_DQ, 1'b0);
                send_item(plain_byte(), 1'b0);
                send_item(CH_LF, 1'b0);
            end
            4: begin
                send_item(CH_SQ, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            5: begin
                send_item(CH_SQ, 1'b0);
                send_item(CH_TAB, 1'b0);
            end
            6: begin
                send_item(CH_DQ, 1'b0);
                send_item(CH_CR, 1'b0);
            end
            7: begin
                send_item(plain_byte(), 1'b0);
                send_item(CH_BSL, 1'b0);
                send_item(CH_LF, 1'b0);
            end
            8: begin
                send_item(CH_BSL, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                do c = 8'($urandom_range(0, 255)); while (is_escape_letter(c) || c == CH_LF);
                send_item(CH_BSL, 1'b0);
                send_item(c, 1'b0);
            end
        endcase
        repeat (6) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int unsigned random_goal;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        wait_for_results();

        // Mostly tokens, with separators and comments between them; now and
        // then the sender stops until the result channel has drained.
        random_goal = items_accepted + RANDOM_ITEMS;
        while (items_accepted < random_goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_token();
                6, 7: send_separators();
                default: send_comment();
            endcase
            if ($urandom_range(0, 59) == 0) wait_for_results();
        end

        send_ending();

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
